FILE: rtl/s27ag_pkg.sv
// Shared types and constants for the 27-point stencil address generator.
package s27ag_pkg;

	localparam int DIM_W      = 11;
	localparam int EB_W       = 7;
	localparam int SWEEP_W    = 16;
	localparam int ADDR_W     = 37;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NEIGHBOURS = 27;

	localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_BEGIN       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_END         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT   = 3'd6;

	// register reset values
	localparam logic [DIM_W-1:0]   SIZE_RST        = 11'd10;
	localparam logic [EB_W-1:0]    EB_RST          = 7'd8;
	localparam logic [DIM_W-1:0]   Z_BEGIN_RST     = 11'd0;
	localparam logic [DIM_W-1:0]   Z_END_RST       = 11'd10;
	localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RST = 16'd1;

	// settings as the datapath sees them, extents already clamped
	typedef struct packed {
		logic [DIM_W-1:0]   nx;
		logic [DIM_W-1:0]   ny;
		logic [DIM_W-1:0]   nz;
		logic [EB_W-1:0]    eb;
		logic [DIM_W-1:0]   z_begin;
		logic [DIM_W-1:0]   z_end;
		logic [SWEEP_W-1:0] sweep_count;
	} cfg_t;

	// one classified point, front to back
	typedef struct packed {
		logic             stencil;
		logic [DIM_W-1:0] cx;
		logic [DIM_W-1:0] cy;
		logic [DIM_W-1:0] cz;
		logic             last_sweep;
		logic             done;
	} cmd_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

endpackage

FILE: rtl/s27ag_if.sv
// Channel interfaces: advance input, request output, configuration writes.
interface s27ag_adv_if;
	logic valid;
	logic ready;
	logic restart;
	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface s27ag_req_if import s27ag_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;
	logic [EB_W-1:0]   req_bytes;
	logic              req_valid;
	logic              is_write;
	logic              last_of_point;
	logic              last_of_sweep;
	logic              all_done;
	logic              range_error;
	modport source(output valid, output address, output req_bytes, output req_valid,
		output is_write, output last_of_point, output last_of_sweep, output all_done,
		output range_error, input ready);
	modport sink(input valid, input address, input req_bytes, input req_valid,
		input is_write, input last_of_point, input last_of_sweep, input all_done,
		input range_error, output ready);
endinterface

interface s27ag_cfg_if import s27ag_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/s27ag_front.sv
// Front end: takes advance words, walks the centre point, classifies each point.
module s27ag_front import s27ag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	s27ag_adv_if.sink  advance,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [DIM_W-1:0]   cx_q, cy_q, cz_q;
	logic [SWEEP_W-1:0] sweeps_q;
	logic [DIM_W-1:0]   cx_n, cy_n, cz_n, z_start;
	logic [SWEEP_W-1:0] sweeps_n, sweeps_inc;
	logic               empty, adv_x, adv_y, adv_z, ends;

	assign advance.ready = !q_full;
	assign push          = advance.valid && !q_full;

	assign z_start    = cfg.z_begin + 11'd1;
	assign sweeps_inc = sweeps_q + 16'd1;
	assign empty      = (cfg.nx < 11'd3) || (cfg.ny < 11'd3) ||
	                    ({1'b0, cfg.z_end} < ({1'b0, cfg.z_begin} + 12'd3));
	assign adv_x      = ({1'b0, cx_q} + 12'd1) < ({1'b0, cfg.nx} - 12'd1);
	assign adv_y      = ({1'b0, cy_q} + 12'd1) < ({1'b0, cfg.ny} - 12'd1);
	assign adv_z      = ({1'b0, cz_q} + 12'd1) < ({1'b0, cfg.z_end} - 12'd1);

	always_comb begin
		cx_n           = cx_q;
		cy_n           = cy_q;
		cz_n           = cz_q;
		sweeps_n       = sweeps_q;
		ends           = 1'b0;
		cmd.stencil    = 1'b0;
		cmd.cx         = cx_q;
		cmd.cy         = cy_q;
		cmd.cz         = cz_q;
		cmd.last_sweep = 1'b0;
		cmd.done       = 1'b1;
		if (advance.restart) begin
			cx_n     = 11'd1;
			cy_n     = 11'd1;
			cz_n     = z_start;
			sweeps_n = '0;
			cmd.done = (cfg.sweep_count == '0);
		end else if (sweeps_q == cfg.sweep_count) begin
			cmd.done = 1'b1;
		end else if (empty) begin
			sweeps_n       = sweeps_inc;
			cmd.last_sweep = 1'b1;
			cmd.done       = (sweeps_inc == cfg.sweep_count);
		end else begin
			if (adv_x) begin
				cx_n = cx_q + 11'd1;
			end else begin
				cx_n = 11'd1;
				if (adv_y) begin
					cy_n = cy_q + 11'd1;
				end else begin
					cy_n = 11'd1;
					if (adv_z) begin
						cz_n = cz_q + 11'd1;
					end else begin
						cz_n = z_start;
						ends = 1'b1;
					end
				end
			end
			sweeps_n       = ends ? sweeps_inc : sweeps_q;
			cmd.stencil    = 1'b1;
			cmd.last_sweep = ends;
			cmd.done       = (sweeps_n == cfg.sweep_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= 11'd1;
			cy_q     <= 11'd1;
			cz_q     <= Z_BEGIN_RST + 11'd1;
			sweeps_q <= '0;
		end else if (push) begin
			cx_q     <= cx_n;
			cy_q     <= cy_n;
			cz_q     <= cz_n;
			sweeps_q <= sweeps_n;
		end
	end

endmodule

FILE: rtl/s27ag_queue.sv
// Small FIFO of classified points between front and back end.
module s27ag_queue import s27ag_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/s27ag_back.sv
// Back end: 28 words per regular point, one per unstalled cycle.
module s27ag_back import s27ag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  cmd_t        q_head,
	output logic        pop,
	s27ag_req_if.source req
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NOREQ = 3'd1;
	localparam logic [2:0] ST_MUL0  = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_MUL2  = 3'd4;
	localparam logic [2:0] ST_MUL3  = 3'd5;
	localparam logic [2:0] ST_MUL4  = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	localparam int PROD_W = ADDR_W + 2;

	logic [2:0]        state_q;
	cmd_t              cmd_q;
	logic [20:0]       plane_q;
	logic [17:0]       nxe_q, xo_q;
	logic [27:0]       pe_q;
	logic [28:0]       yo_q;
	logic [ADDR_W-1:0] zo_q, wb_q, yx_q, ctr_q, bk_q;
	logic [ADDR_W-1:0] pln_q, row_q, col_q, wr_q;
	logic [1:0]        ix_q, iy_q, iz_q;
	logic              wr_phase_q;

	logic              vld_q;
	logic [ADDR_W-1:0] addr_q;
	logic [EB_W-1:0]   bytes_q;
	logic              rv_q, wr_q_flag, lp_q, ls_q, done_q, err_q;

	logic [PROD_W-1:0] zo_full, wb_full;
	logic [ADDR_W-1:0] row_step, pln_step;
	logic [DIM_W:0]    px, py, pz;
	logic              rd_bad, wr_bad, slot_free;

	assign slot_free = !vld_q || req.ready;
	assign pop       = (state_q == ST_IDLE) && q_valid;

	assign zo_full  = PROD_W'(cmd_q.cz) * PROD_W'(pe_q);
	assign wb_full  = PROD_W'(cfg.nz) * PROD_W'(pe_q);
	assign row_step = row_q + ADDR_W'(nxe_q);
	assign pln_step = pln_q + ADDR_W'(pe_q);

	// an underflow wraps to all ones and fails the upper bound as well
	assign px     = {1'b0, cmd_q.cx} + 12'(ix_q) - 12'd1;
	assign py     = {1'b0, cmd_q.cy} + 12'(iy_q) - 12'd1;
	assign pz     = {1'b0, cmd_q.cz} + 12'(iz_q) - 12'd1;
	assign rd_bad = (px >= {1'b0, cfg.nx}) || (py >= {1'b0, cfg.ny}) ||
	                (pz >= {1'b0, cfg.nz});
	assign wr_bad = (cmd_q.cx >= cfg.nx) || (cmd_q.cy >= cfg.ny) || (cmd_q.cz >= cfg.nz);

	assign req.valid         = vld_q;
	assign req.address       = addr_q;
	assign req.req_bytes     = bytes_q;
	assign req.req_valid     = rv_q;
	assign req.is_write      = wr_q_flag;
	assign req.last_of_point = lp_q;
	assign req.last_of_sweep = ls_q;
	assign req.all_done      = done_q;
	assign req.range_error   = err_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
		end
		case (state_q)
			ST_MUL0: begin
				plane_q <= 21'(cfg.nx) * 21'(cfg.ny);
				nxe_q   <= 18'(cfg.nx) * 18'(cfg.eb);
				xo_q    <= 18'(cmd_q.cx) * 18'(cfg.eb);
			end
			ST_MUL1: begin
				pe_q <= 28'(plane_q) * 28'(cfg.eb);
				yo_q <= 29'(cmd_q.cy) * 29'(nxe_q);
			end
			ST_MUL2: begin
				zo_q <= zo_full[ADDR_W-1:0];
				wb_q <= wb_full[ADDR_W-1:0];
				yx_q <= ADDR_W'(yo_q) + ADDR_W'(xo_q);
			end
			ST_MUL3: begin
				ctr_q <= zo_q + yx_q;
				bk_q  <= ADDR_W'(pe_q) + ADDR_W'(nxe_q) + ADDR_W'(cfg.eb);
			end
			ST_MUL4: begin
				pln_q <= ctr_q - bk_q;
				row_q <= ctr_q - bk_q;
				col_q <= ctr_q - bk_q;
				wr_q  <= wb_q + ctr_q;
			end
			ST_EMIT: begin
				if (slot_free && !wr_phase_q) begin
					if (ix_q != 2'd2) begin
						col_q <= col_q + ADDR_W'(cfg.eb);
					end else if (iy_q != 2'd2) begin
						row_q <= row_step;
						col_q <= row_step;
					end else begin
						pln_q <= pln_step;
						row_q <= pln_step;
						col_q <= pln_step;
					end
				end
			end
			default: begin
			end
		endcase
		if (slot_free) begin
			if (state_q == ST_NOREQ) begin
				addr_q    <= '0;
				bytes_q   <= '0;
				rv_q      <= 1'b0;
				wr_q_flag <= 1'b0;
				lp_q      <= 1'b1;
				ls_q      <= cmd_q.last_sweep;
				done_q    <= cmd_q.done;
				err_q     <= 1'b0;
			end else if (state_q == ST_EMIT) begin
				addr_q    <= wr_phase_q ? (wr_bad ? '0 : wr_q) : (rd_bad ? '0 : col_q);
				bytes_q   <= cfg.eb;
				rv_q      <= 1'b1;
				wr_q_flag <= wr_phase_q;
				lp_q      <= wr_phase_q;
				ls_q      <= cmd_q.last_sweep;
				done_q    <= cmd_q.done;
				err_q     <= wr_phase_q ? wr_bad : rd_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= 1'b0;
			ix_q       <= '0;
			iy_q       <= '0;
			iz_q       <= '0;
			wr_phase_q <= 1'b0;
		end else begin
			if (slot_free) begin
				vld_q <= (state_q == ST_NOREQ) || (state_q == ST_EMIT);
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= q_head.stencil ? ST_MUL0 : ST_NOREQ;
					end
				end
				ST_NOREQ: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_MUL4;
				ST_MUL4: begin
					ix_q       <= '0;
					iy_q       <= '0;
					iz_q       <= '0;
					wr_phase_q <= 1'b0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (wr_phase_q) begin
							state_q <= ST_IDLE;
						end else if (ix_q != 2'd2) begin
							ix_q <= ix_q + 2'd1;
						end else begin
							ix_q <= '0;
							if (iy_q != 2'd2) begin
								iy_q <= iy_q + 2'd1;
							end else begin
								iy_q <= '0;
								if (iz_q != 2'd2) begin
									iz_q <= iz_q + 2'd1;
								end else begin
									wr_phase_q <= 1'b1;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/stencil27_address_generator.sv
// 27-point stencil address generator, top level.
//
// advance: one word per grid point. restart=1 returns to the first point of
//   the first sweep; restart=0 moves on one interior point.
// req: the words caused by one advance word. A regular point gives 27
//   neighbour reads (z, then y, then x, each from -1 to +1) and one write of
//   the centre, marked last_of_point. Restart, an empty sweep or a finished
//   run gives one word without a request.
// cfg: register writes by index, always ready; write only while idle.
// Flow: an advance word passes through the queue to the back end; a regular
//   point then forms its base addresses in the multiplier states MUL0 to
//   MUL4 and emits one request per cycle while req does not stall. A point
//   with no request goes from idle through the NOREQ state back to idle.
// A two-entry queue decouples the front end, which keeps accepting advance
//   words while the back end is busy. When req stalls, the output register
//   holds its word and the back end waits; the queue fills, then advance
//   deasserts ready.
// Reset clears the centre to the first point, the sweep count to zero and
//   the registers to their defaults; no request is pending afterwards.
module stencil27_address_generator import s27ag_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	s27ag_adv_if.sink   advance,
	s27ag_req_if.source req,
	s27ag_cfg_if.sink   cfg
);

	logic [DIM_W-1:0]   size_x_q, size_y_q, size_z_q, z_begin_q, z_end_q;
	logic [EB_W-1:0]    eb_q;
	logic [SWEEP_W-1:0] sweep_count_q;
	cfg_t               cfg_w;
	cmd_t               push_cmd, head_cmd;
	logic               push, q_full, q_valid, pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q      <= SIZE_RST;
			size_y_q      <= SIZE_RST;
			size_z_q      <= SIZE_RST;
			eb_q          <= EB_RST;
			z_begin_q     <= Z_BEGIN_RST;
			z_end_q       <= Z_END_RST;
			sweep_count_q <= SWEEP_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SIZE_X:        size_x_q      <= cfg.data[DIM_W-1:0];
				REG_SIZE_Y:        size_y_q      <= cfg.data[DIM_W-1:0];
				REG_SIZE_Z:        size_z_q      <= cfg.data[DIM_W-1:0];
				REG_ELEMENT_BYTES: eb_q          <= cfg.data[EB_W-1:0];
				REG_Z_BEGIN:       z_begin_q     <= cfg.data[DIM_W-1:0];
				REG_Z_END:         z_end_q       <= cfg.data[DIM_W-1:0];
				REG_SWEEP_COUNT:   sweep_count_q <= cfg.data[SWEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_w.nx          = clamp_dim(size_x_q);
		cfg_w.ny          = clamp_dim(size_y_q);
		cfg_w.nz          = clamp_dim(size_z_q);
		cfg_w.eb          = eb_q;
		cfg_w.z_begin     = z_begin_q;
		cfg_w.z_end       = z_end_q;
		cfg_w.sweep_count = sweep_count_q;
	end

	s27ag_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_w),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd)
	);

	s27ag_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (head_cmd)
	);

	s27ag_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_w),
		.q_valid (q_valid),
		.q_head  (head_cmd),
		.pop     (pop),
		.req     (req)
	);

endmodule

FILE: rtl/s27ag_checker.sv
// Port-level checks on the request channel, bound to the top level.
module s27ag_checker import s27ag_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              valid,
	input logic              ready,
	input logic [ADDR_W-1:0] address,
	input logic              req_valid,
	input logic              is_write,
	input logic              last_of_point,
	input logic              range_error
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(address) && $stable(last_of_point))
		else $error("stalled request word changed");

	a_noreq_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !req_valid |-> last_of_point && !is_write && !range_error && (address == '0))
		else $error("word without request is not a clean point end");

	a_write_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && req_valid |-> (is_write == last_of_point))
		else $error("centre write and point end disagree");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && range_error |-> (address == '0))
		else $error("out-of-grid request carries an address");

endmodule

bind stencil27_address_generator s27ag_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (req.valid),
	.ready         (req.ready),
	.address       (req.address),
	.req_valid     (req.req_valid),
	.is_write      (req.is_write),
	.last_of_point (req.last_of_point),
	.range_error   (req.range_error)
);
